FILE: hdl/ecu_pkg.sv
// Shared constants and types for the universal code encoder.
package ecu_pkg;

	localparam int DEFAULT_VALUE_BITS = 31;
	localparam int CODE_BITS          = 61;
	localparam int LEN_BITS           = 6;
	localparam int DATA_BITS          = 32;
	localparam int ADDR_BITS          = 3;

	typedef enum logic [1:0] {
		MODE_GAMMA  = 2'd0,
		MODE_OMEGA  = 2'd1,
		MODE_FIXVAR = 2'd2
	} mode_t;

	typedef enum logic [0:0] {
		REG_CODE_MODE = 1'b0
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_STEP   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

FILE: hdl/ecu_bit_scan.sv
// Iterative bit-length unit: shifts the operand right one place per cycle.
module ecu_bit_scan #(
	parameter int VALUE_BITS = ecu_pkg::DEFAULT_VALUE_BITS,
	parameter int LEN_W      = $clog2(VALUE_BITS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] operand,
	output logic                  done,
	output logic [LEN_W-1:0]      length
);

	logic                  busy_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [LEN_W-1:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= operand;
			count_q <= '0;
		end else if (busy_q && shift_q != '0) begin
			shift_q <= shift_q >> 1;
			count_q <= count_q + LEN_W'(1);
		end
	end

	// The scan ends once every set bit has been shifted out.
	assign done   = busy_q && (shift_q == '0);
	assign length = count_q;

endmodule

FILE: hdl/elias_universal_code_encoder.sv
// Top level of the Elias gamma, omega and fixed-plus-variable encoder.
// Each pass of the bit-length scan shifts the operand out one place at a time; gamma and
// fixed-plus-variable make one pass on the value, omega one on the value and one on each
// length minus one down to one, and out_valid rises once the last pass ends.
// One word at a time: the next is accepted in the cycle after the result is registered, or later.
// Reset (arst_n, asynchronous) clears code_mode to gamma and empties the output register.
module elias_universal_code_encoder #(
	parameter int VALUE_BITS = ecu_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ecu_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [ecu_pkg::DATA_BITS-1:0]    pwdata,
	output logic [ecu_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [VALUE_BITS-1:0]            value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ecu_pkg::CODE_BITS-1:0]    code_bits,
	output logic [ecu_pkg::LEN_BITS-1:0]     code_length
);

	localparam int LEN_W = $clog2(VALUE_BITS + 1);

	ecu_pkg::state_t               state_q;
	logic [1:0]                    code_mode_q;
	logic [1:0]                    mode_q;
	logic [VALUE_BITS-1:0]         k_q;
	logic [ecu_pkg::CODE_BITS-1:0] acc_q;
	logic [ecu_pkg::LEN_BITS-1:0]  total_q;
	logic [ecu_pkg::CODE_BITS-1:0] res_bits_q;
	logic [ecu_pkg::LEN_BITS-1:0]  res_len_q;
	logic                          out_valid_q;
	logic [ecu_pkg::CODE_BITS-1:0] out_bits_q;
	logic [ecu_pkg::LEN_BITS-1:0]  out_len_q;

	logic                  reg_sel;
	logic                  in_take;
	logic                  out_free;
	logic                  scan_start;
	logic [VALUE_BITS-1:0] scan_operand;
	logic                  scan_done;
	logic [LEN_W-1:0]      scan_len;
	logic [LEN_W-1:0]      len_q;
	logic [VALUE_BITS-1:0] k_next;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_mode_q <= ecu_pkg::MODE_GAMMA;
		end else if (psel && penable && pwrite && pready
		             && reg_sel == ecu_pkg::REG_CODE_MODE) begin
			code_mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == ecu_pkg::REG_CODE_MODE) begin
			prdata = {{(ecu_pkg::DATA_BITS-2){1'b0}}, code_mode_q};
		end
	end

	// Handshakes
	assign in_stall = (state_q != ecu_pkg::ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The next omega group is the length just measured, minus one.
	assign k_next = VALUE_BITS'(len_q - LEN_W'(1));

	// Shared bit-length unit
	assign scan_start   = in_take || (state_q == ecu_pkg::ST_STEP);
	assign scan_operand = in_take ? value : k_next;

	ecu_bit_scan #(
		.VALUE_BITS (VALUE_BITS),
		.LEN_W      (LEN_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.operand (scan_operand),
		.done    (scan_done),
		.length  (scan_len)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecu_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				ecu_pkg::ST_IDLE: begin
					if (in_take) begin
						state_q <= ecu_pkg::ST_SCAN;
					end
				end
				ecu_pkg::ST_SCAN: begin
					if (scan_done) begin
						if (mode_q == ecu_pkg::MODE_OMEGA && scan_len > LEN_W'(1)) begin
							state_q <= ecu_pkg::ST_STEP;
						end else begin
							state_q <= ecu_pkg::ST_FINISH;
						end
					end
				end
				ecu_pkg::ST_STEP: begin
					state_q <= ecu_pkg::ST_SCAN;
				end
				ecu_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= ecu_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ecu_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: in omega mode one group of the code is placed in each step between passes through the scan.
	always_ff @(posedge clk) begin
		if (in_take) begin
			k_q     <= value;
			mode_q  <= code_mode_q;
			acc_q   <= '0;
			total_q <= ecu_pkg::LEN_BITS'(1);
		end else if (state_q == ecu_pkg::ST_SCAN && scan_done) begin
			len_q <= scan_len;
			unique case (mode_q)
				ecu_pkg::MODE_GAMMA, ecu_pkg::MODE_FIXVAR: begin
					res_bits_q <= {{(ecu_pkg::CODE_BITS-VALUE_BITS){1'b0}}, k_q};
					if (scan_len == '0) begin
						res_len_q <= (mode_q == ecu_pkg::MODE_FIXVAR)
						             ? ecu_pkg::LEN_BITS'(1) : '0;
					end else begin
						res_len_q <= (ecu_pkg::LEN_BITS'(scan_len) << 1)
						             - ecu_pkg::LEN_BITS'(1);
					end
				end
				ecu_pkg::MODE_OMEGA: begin
					res_bits_q <= acc_q;
					res_len_q  <= (scan_len == '0) ? '0 : total_q;
				end
				default: begin
					res_bits_q <= '0;
					res_len_q  <= '0;
				end
			endcase
		end else if (state_q == ecu_pkg::ST_STEP) begin
			// The group just measured goes above the bits already placed.
			acc_q   <= acc_q
			           | ({{(ecu_pkg::CODE_BITS-VALUE_BITS){1'b0}}, k_q} << total_q);
			total_q <= total_q + ecu_pkg::LEN_BITS'(len_q);
			k_q     <= k_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ecu_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ecu_pkg::ST_FINISH && out_free) begin
			out_bits_q <= res_bits_q;
			out_len_q  <= res_len_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_bits   = out_bits_q;
	assign code_length = out_len_q;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the Elias universal code encoder: words after reset, directed corners, then random words.
`timescale 1ns / 100ps

module tb_top;

	localparam int          VBITS       = ecu_pkg::DEFAULT_VALUE_BITS;
	localparam logic [ecu_pkg::ADDR_BITS-1:0] MODE_ADDR =
		ecu_pkg::ADDR_BITS'(4 * int'(ecu_pkg::REG_CODE_MODE));
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [ecu_pkg::CODE_BITS-1:0] bits;
		logic [ecu_pkg::LEN_BITS-1:0]  len;
	} code_word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [ecu_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [ecu_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [ecu_pkg::DATA_BITS-1:0] prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [VBITS-1:0]              value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [ecu_pkg::CODE_BITS-1:0] code_bits;
	logic [ecu_pkg::LEN_BITS-1:0]  code_length;

	code_word_t  pending_words[$];
	logic [1:0]  code_mode_shadow = ecu_pkg::MODE_GAMMA;
	bit          calm = 1'b0;
	int          error_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;

	elias_universal_code_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_bits   (code_bits),
		.code_length (code_length)
	);

	always #10 clk = ~clk;

	function automatic int bit_len(input logic [63:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	function automatic code_word_t encode_value(input logic [1:0] mode,
			input logic [VBITS-1:0] v);
		code_word_t  w;
		logic [63:0] acc;
		logic [63:0] k;
		int          total;
		int          l;
		w = '0;
		if (v == 0) begin
			// Zero is empty everywhere except in the fixed-plus-variable code.
			if (mode == ecu_pkg::MODE_FIXVAR)
				w.len = ecu_pkg::LEN_BITS'(1);
			return w;
		end
		unique case (mode)
			ecu_pkg::MODE_GAMMA, ecu_pkg::MODE_FIXVAR: begin
				w.bits = ecu_pkg::CODE_BITS'(v);
				w.len  = ecu_pkg::LEN_BITS'(2 * bit_len(64'(v)) - 1);
			end
			ecu_pkg::MODE_OMEGA: begin
				// Groups are placed above the closing zero, the last computed one on top.
				acc   = '0;
				total = 1;
				k     = 64'(v);
				while (k > 1 && total < ecu_pkg::CODE_BITS) begin
					l     = bit_len(k);
					acc   = acc | (k << total);
					total = total + l;
					k     = 64'(l - 1);
				end
				w.bits = acc[ecu_pkg::CODE_BITS-1:0];
				w.len  = ecu_pkg::LEN_BITS'(total);
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Receiver back-pressure: after each word taken, stall for a random number of cycles.
	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) begin
			stall_left = calm ? 0 : $urandom_range(0, 6);
			out_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		code_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: code_bits %h code_length %0d", code_bits, code_length);
				error_count++;
			end else begin
				want = pending_words.pop_front();
				if (code_bits !== want.bits) begin
					$error("code_bits: expected %h, got %h", want.bits, code_bits);
					error_count++;
				end
				if (code_length !== want.len) begin
					$error("code_length: expected %0d, got %0d", want.len, code_length);
					error_count++;
				end
			end
		end
	end

	task automatic send_value(input logic [VBITS-1:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_words.push_back(encode_value(code_mode_shadow, v));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write code_mode while the encoder is idle, then read it back.
	task automatic set_code_mode(input logic [1:0] mode);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= ecu_pkg::DATA_BITS'(mode);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		code_mode_shadow = mode;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== ecu_pkg::DATA_BITS'(mode)) begin
			$error("prdata: expected %h, got %h", ecu_pkg::DATA_BITS'(mode), prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Words sent straight after reset must come out in gamma.
	task automatic test_reset_mode();
		calm = 1'b0;
		send_value('0);
		send_value(VBITS'(1));
		send_value(VBITS'(5));
		send_value('1);
	endtask

	task automatic test_directed();
		logic [VBITS-1:0] corner_values[5];
		logic [1:0]       mode;
		corner_values = '{VBITS'(0), VBITS'(1), VBITS'(2), VBITS'(3), {VBITS{1'b1}}};
		for (int m = 0; m < 4; m++) begin
			mode = 2'(m);
			set_code_mode(mode);
			calm = (m % 2 == 1);
			foreach (corner_values[i])
				send_value(corner_values[i]);
		end
	endtask

	task automatic test_random();
		logic [VBITS-1:0] v;
		logic [1:0]       mode;
		int               n;
		int               phases;
		int               per_phase;
		phases    = 8;
		per_phase = RANDOM_ITEMS / phases;
		for (int p = 0; p < phases; p++) begin
			// The first four phases walk through every mode, the rest pick at random.
			mode = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
			set_code_mode(mode);
			for (int i = 0; i < per_phase; i++) begin
				if (i % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// Draw the bit length first so that short and long values are equally likely.
				n = $urandom_range(0, VBITS);
				v = VBITS'($urandom);
				if (n == 0) begin
					v = '0;
				end else begin
					v = v & ((VBITS'(1) << n) - VBITS'(1));
					v[n-1] = 1'b1;
				end
				send_value(v);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_mode();
		test_directed();
		test_random();
		set_code_mode(ecu_pkg::MODE_GAMMA);
		wait_idle();
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
